### hw/rtl/hss_pkg.sv
// hss_pkg: shared types and constants of the heat stencil sweep.
// Used by the front, queue, back and top modules; depends on nothing.
`timescale 1ns / 1ps

package hss_pkg;

    localparam int TEMP_W      = 32;   // Q16.16 temperature
    localparam int COEF_W      = 16;   // diffusion coefficient register
    localparam int GW_W        = 11;   // grid_width register
    localparam int SUM_W       = 35;   // exact stencil sum
    localparam int ENTRY_W     = TEMP_W + 1;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;
    localparam int QUEUE_DEPTH = 4;
    localparam int CENTRE_SHIFT = 2;   // times four on the centre cell
    localparam int MIN_GRID_WIDTH = 3;

    localparam logic [GW_W-1:0]   GRID_WIDTH_RST = 11'd1024;
    localparam logic [COEF_W-1:0] COEF_RST       = 16'd16384;

    localparam logic CFG_IDX_GRID_WIDTH = 1'b0;
    localparam logic CFG_IDX_COEF       = 1'b1;

    localparam logic KIND_GRID    = 1'b0;
    localparam logic KIND_PADDING = 1'b1;

    typedef enum logic {
        PH_FIRST_ROW,
        PH_STREAM
    } t_row_phase;

    // one classified cell handed from the front to the back
    typedef struct packed {
        logic              last;      // last column of its row
        logic              init_row;  // first grid row: store only, no result
        logic              pad;       // padding cell
        logic              fixed;     // fixed flag (zero for padding)
        logic [TEMP_W-1:0] temp;      // temperature (zero for padding)
    } t_cmd;

endpackage

### hw/rtl/hss_front.sv
// hss_front: accepts cells, tracks column and row phase, drops stray padding.
// Depends on hss_pkg.
`timescale 1ns / 1ps

module hss_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [hss_pkg::GW_W-1:0]     i_grid_width,
    input  logic                         i_s_valid,
    output logic                         o_s_ready,
    input  logic                         i_kind,
    input  logic [hss_pkg::TEMP_W-1:0]   i_temp,
    input  logic                         i_fixed,
    input  logic                         i_q_full,
    output logic                         o_push,
    output logic [$clog2(MAX_WIDTH)-1:0] o_col,
    output hss_pkg::t_cmd                o_cmd
);
    import hss_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = ($clog2(MAX_WIDTH + 1) > GW_W) ? $clog2(MAX_WIDTH + 1) : GW_W;

    t_row_phase    r_phase;
    t_row_phase    n_phase;
    logic [CW-1:0] r_col;
    logic [CW-1:0] n_col;

    logic [WW-1:0] gw;
    logic [WW-1:0] eff_w;
    logic [WW-1:0] last_col;
    logic          last;
    logic          pad;
    logic          drop;
    logic          init_row;
    logic          take;

    // clamp the width to the supported range
    always_comb begin
        gw = WW'(i_grid_width);
        if (gw < WW'(MIN_GRID_WIDTH)) begin
            eff_w = WW'(MIN_GRID_WIDTH);
        end else if (gw > WW'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = gw;
        end
        last_col = eff_w - WW'(1);
        last     = WW'(r_col) >= last_col;
    end

    assign pad       = (i_kind == KIND_PADDING);
    assign o_s_ready = !i_q_full;
    assign take      = i_s_valid && o_s_ready;

    // outputs of the phase machine
    always_comb begin
        case (r_phase)
            PH_FIRST_ROW: begin
                init_row = 1'b1;
                drop     = pad;
            end
            PH_STREAM: begin
                init_row = 1'b0;
                drop     = 1'b0;
            end
            default: begin
                init_row = 1'b0;
                drop     = 1'b0;
            end
        endcase
    end

    assign o_push = take && !drop;

    // next state of the phase machine
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_FIRST_ROW: begin
                if (o_push && last) begin
                    n_phase = PH_STREAM;
                end
            end
            PH_STREAM: begin
                if (o_push && last && pad) begin
                    n_phase = PH_FIRST_ROW;
                end
            end
            default: n_phase = PH_FIRST_ROW;
        endcase
    end

    always_comb begin
        n_col = r_col;
        if (o_push) begin
            n_col = last ? '0 : r_col + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST_ROW;
            r_col   <= '0;
        end else begin
            r_phase <= n_phase;
            r_col   <= n_col;
        end
    end

    // padding reads as a zero cell
    assign o_col          = r_col;
    assign o_cmd.last     = last;
    assign o_cmd.init_row = init_row;
    assign o_cmd.pad      = pad;
    assign o_cmd.fixed    = pad ? 1'b0 : i_fixed;
    assign o_cmd.temp     = pad ? '0 : i_temp;

endmodule

### hw/rtl/hss_cmd_queue.sv
// hss_cmd_queue: short register queue between front and back.
// Depends on hss_pkg for its depth.
`timescale 1ns / 1ps

module hss_cmd_queue #(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);
    import hss_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] r_slot [QUEUE_DEPTH];
    logic [PW-1:0]     r_wr_ptr;
    logic [PW-1:0]     r_rd_ptr;
    logic [NW-1:0]     r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == NW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + NW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - NW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

### hw/rtl/hss_back.sv
// hss_back: line buffers and the stencil update pipeline.
// Depends on hss_pkg.
`timescale 1ns / 1ps

module hss_back #(
    parameter int MAX_WIDTH      = 1024,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [hss_pkg::COEF_W-1:0]   i_coef,
    input  logic                         i_q_valid,
    output logic                         o_q_pop,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_col,
    input  hss_pkg::t_cmd                i_cmd,
    input  logic                         i_m_ready,
    output logic                         o_m_valid,
    output logic [hss_pkg::TEMP_W-1:0]   o_new_temp,
    output logic                         o_fixed,
    output logic                         o_end,
    output logic                         o_sat
);
    import hss_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int PW = SUM_W + COEF_W + 1;
    localparam logic [PW-1:0] ROUND_HALF = {{(PW-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);

    // line buffers: bit 32 fixed flag, bits 31..0 temperature
    logic [ENTRY_W-1:0] r_older [MAX_WIDTH];
    logic [ENTRY_W-1:0] r_prev  [MAX_WIDTH];

    logic               adv;
    logic               pop;
    logic [CW-1:0]      col_nxt;

    logic [ENTRY_W-1:0] r_rd_up;
    logic [ENTRY_W-1:0] r_rd_ctr;
    logic [ENTRY_W-1:0] r_rd_rgt;
    logic [TEMP_W-1:0]  r_left;

    logic               r_a_valid;
    logic [CW-1:0]      r_a_col;
    logic               r_a_last;
    logic               r_a_init;
    logic               r_a_pad;
    logic [TEMP_W-1:0]  r_a_down;

    logic signed [SUM_W-1:0] sum_a;
    logic                    pass_a;

    logic                    r_b_valid;
    logic [TEMP_W-1:0]       r_b_temp;
    logic                    r_b_fixed;
    logic                    r_b_pass;
    logic                    r_b_end;
    logic signed [SUM_W-1:0] r_b_sum;

    logic                    r_c_valid;
    logic [TEMP_W-1:0]       r_c_temp;
    logic                    r_c_fixed;
    logic                    r_c_pass;
    logic                    r_c_end;
    logic signed [PW-1:0]    r_c_prod;

    logic signed [PW-1:0]    rnd_c;
    logic signed [PW-1:0]    res_c;
    logic                    ovf_c;
    logic [TEMP_W-1:0]       val_c;

    logic                    r_out_valid;
    logic [TEMP_W-1:0]       r_out_temp;
    logic                    r_out_fixed;
    logic                    r_out_end;
    logic                    r_out_sat;

    // the whole pipe moves while the output register can take a result
    assign adv     = !r_out_valid || i_m_ready;
    assign pop     = adv && i_q_valid;
    assign o_q_pop = pop;
    assign col_nxt = i_col + CW'(1);

    // current row store: write the arriving cell, read centre and right
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_prev[i_col] <= {i_cmd.fixed, i_cmd.temp};
        end
        if (adv) begin
            r_rd_ctr <= r_prev[i_col];
            r_rd_rgt <= r_prev[col_nxt];
        end
    end

    // older row store: read up, write back the centre held in stage A
    always_ff @(posedge i_clk) begin
        if (adv && r_a_valid) begin
            r_older[r_a_col] <= r_a_init ? '0 : r_rd_ctr;
        end
        if (adv) begin
            r_rd_up <= r_older[i_col];
        end
    end

    // stage A: stencil sum
    always_comb begin
        sum_a = SUM_W'($signed(r_left)) + SUM_W'($signed(r_rd_up[TEMP_W-1:0]))
              + SUM_W'($signed(r_rd_rgt[TEMP_W-1:0])) + SUM_W'($signed(r_a_down))
              - (SUM_W'($signed(r_rd_ctr[TEMP_W-1:0])) <<< CENTRE_SHIFT);
        pass_a = r_rd_ctr[TEMP_W] || (r_a_col == '0) || r_a_last;
    end

    // stage C: round, add, clip
    always_comb begin
        rnd_c = (r_c_prod + $signed(ROUND_HALF)) >>> COEF_FRAC_BITS;
        res_c = rnd_c + PW'($signed(r_c_temp));
        ovf_c = !((&res_c[PW-1:TEMP_W-1]) || !(|res_c[PW-1:TEMP_W-1]));
        if (ovf_c) begin
            val_c = res_c[PW-1] ? {1'b1, {(TEMP_W-1){1'b0}}} : {1'b0, {(TEMP_W-1){1'b1}}};
        end else begin
            val_c = res_c[TEMP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid   <= pop;
            r_b_valid   <= r_a_valid && !r_a_init;
            r_c_valid   <= r_b_valid;
            r_out_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_col  <= i_col;
            r_a_last <= i_cmd.last;
            r_a_init <= i_cmd.init_row;
            r_a_pad  <= i_cmd.pad;
            r_a_down <= i_cmd.temp;
            if (r_a_valid) begin
                r_left <= r_rd_ctr[TEMP_W-1:0];
            end

            r_b_temp  <= r_rd_ctr[TEMP_W-1:0];
            r_b_fixed <= r_rd_ctr[TEMP_W];
            r_b_pass  <= pass_a;
            r_b_end   <= r_a_pad && r_a_last;
            r_b_sum   <= sum_a;

            r_c_temp  <= r_b_temp;
            r_c_fixed <= r_b_fixed;
            r_c_pass  <= r_b_pass;
            r_c_end   <= r_b_end;
            r_c_prod  <= PW'(r_b_sum) * PW'($signed({1'b0, i_coef}));

            r_out_temp  <= r_c_pass ? r_c_temp : val_c;
            r_out_fixed <= r_c_fixed;
            r_out_end   <= r_c_end;
            r_out_sat   <= !r_c_pass && ovf_c;
        end
    end

    assign o_m_valid  = r_out_valid;
    assign o_new_temp = r_out_temp;
    assign o_fixed    = r_out_fixed;
    assign o_end      = r_out_end;
    assign o_sat      = r_out_sat;

endmodule

### hw/rtl/heat_stencil_sweep.sv
// heat_stencil_sweep: top level of one explicit 5-point heat diffusion step.
// Instantiates hss_front, hss_cmd_queue and hss_back; depends on hss_pkg.
//
//  channel  | direction | handshake                     | payload
//  ---------+-----------+-------------------------------+----------------------------------
//  s_axis   | in        | s_axis_tvalid / s_axis_tready | tdata: temperature, fixed_cell
//           |           |                               | tuser: kind
//  m_axis   | out       | m_axis_tvalid / m_axis_tready | tdata: new_temperature,
//           |           |                               |        cell_fixed; tuser: saturated;
//           |           |                               | tlast: end_of_grid
//  cfg      | in        | i_cfg_valid / o_cfg_ready     | i_cfg_index, i_cfg_data
//
// Flow: one cell per clock while the queue has room; each line buffer does one write per
// accepted cell and its reads on every advance of the back pipe. A result leaves through
// the queue, buffer read, sum, multiply, and round and clip registers after the cell that causes it.
// Reset: synchronous, active low; clears phase, column, queue and stage valid bits and loads the
// register defaults. The line buffers are not cleared; the first grid row writes them.
// Stalls: m_axis_tready low freezes the back pipe while a result waits at the output; the
// four-entry queue keeps s_axis_tready high until it fills. The config port is always ready.
`timescale 1ns / 1ps

module heat_stencil_sweep #(
    parameter int MAX_WIDTH      = 1024,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave stream: cells in raster order
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [hss_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [31:0] temperature, [32] fixed_cell
    input  logic                              s_axis_tuser,  // [0] kind
    // master stream: updated cells of the row above
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [hss_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // [31:0] new_temperature,
                                                             // [32] cell_fixed
    output logic                              m_axis_tuser,  // [0] saturated
    output logic                              m_axis_tlast,  // end_of_grid
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic                              i_cfg_index,
    input  logic [hss_pkg::COEF_W-1:0]        i_cfg_data
);
    import hss_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int QDW = CW + $bits(t_cmd);

    logic [GW_W-1:0]   r_grid_width;
    logic [COEF_W-1:0] r_coef;

    logic              push;
    logic              q_full;
    logic              q_valid;
    logic              q_pop;
    logic [CW-1:0]     front_col;
    t_cmd              front_cmd;
    logic [QDW-1:0]    q_data;
    logic [CW-1:0]     back_col;
    t_cmd              back_cmd;

    logic [TEMP_W-1:0] new_temp;
    logic              out_fixed;

    // Configuration registers: take a write whenever offered.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width <= GRID_WIDTH_RST;
            r_coef       <= COEF_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_IDX_GRID_WIDTH: r_grid_width <= i_cfg_data[GW_W-1:0];
                CFG_IDX_COEF:       r_coef       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front: classify each cell, advance column and row phase.
    hss_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_grid_width (r_grid_width),
        .i_s_valid    (s_axis_tvalid),
        .o_s_ready    (s_axis_tready),
        .i_kind       (s_axis_tuser),
        .i_temp       (s_axis_tdata[TEMP_W-1:0]),
        .i_fixed      (s_axis_tdata[TEMP_W]),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_col        (front_col),
        .o_cmd        (front_cmd)
    );

    // Queue: decouple acceptance from the update pipeline.
    hss_cmd_queue #(
        .DATA_W (QDW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({front_col, front_cmd}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign back_col = q_data[QDW-1 -: CW];
    assign back_cmd = t_cmd'(q_data[$bits(t_cmd)-1:0]);

    // Back: line buffers, stencil sum, multiply, round and clip.
    hss_back #(
        .MAX_WIDTH      (MAX_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_coef     (r_coef),
        .i_q_valid  (q_valid),
        .o_q_pop    (q_pop),
        .i_col      (back_col),
        .i_cmd      (back_cmd),
        .i_m_ready  (m_axis_tready),
        .o_m_valid  (m_axis_tvalid),
        .o_new_temp (new_temp),
        .o_fixed    (out_fixed),
        .o_end      (m_axis_tlast),
        .o_sat      (m_axis_tuser)
    );

    // Pack the result; zero the spare bits up to the byte boundary.
    assign m_axis_tdata = {{(OUT_TDATA_W-TEMP_W-1){1'b0}}, out_fixed, new_temp};

    // The grid end is the last column, which always passes through unclipped.
    a_end_not_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> !m_axis_tuser)
        else $error("end-of-grid result carries the saturated flag");

    // A fixed cell is never updated, so it can never clip.
    a_fixed_not_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> !m_axis_tdata[TEMP_W])
        else $error("fixed cell reported as saturated");

    // A clipped result sits at one end of the Q16.16 range.
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            (m_axis_tdata[TEMP_W-1:0] == 32'h7FFF_FFFF) ||
            (m_axis_tdata[TEMP_W-1:0] == 32'h8000_0000))
        else $error("saturated result is not a range limit");

endmodule

### tb/stencil_result_checker.sv
// stencil_result_checker: watches the cell, result and register channels of the
// heat stencil sweep, predicts every updated cell and compares it field by field.
// Depends on hss_pkg for widths, cell kinds, register indexes and the row phase.
`timescale 1ns / 1ps

module stencil_result_checker #(
    parameter int MAX_WIDTH      = 1024,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cell_valid,
    input  logic                             i_cell_ready,
    input  logic [hss_pkg::IN_TDATA_W-1:0]   i_cell_data,
    input  logic                             i_cell_kind,
    input  logic                             i_result_valid,
    input  logic                             i_result_ready,
    input  logic [hss_pkg::OUT_TDATA_W-1:0]  i_result_data,
    input  logic                             i_result_saturated,
    input  logic                             i_result_last,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic                             i_cfg_index,
    input  logic [hss_pkg::COEF_W-1:0]       i_cfg_data,
    output int                               o_mismatch_count,
    output int                               o_results_pending
);
    import hss_pkg::*;

    localparam longint TEMP_MAX   = 64'sd2147483647;
    localparam longint TEMP_MIN   = -64'sd2147483648;
    localparam longint ROUND_HALF = 64'sd1 <<< (COEF_FRAC_BITS - 1);

    typedef struct packed {
        logic [TEMP_W-1:0] temp;
        logic              fixed;
        logic              end_of_grid;
        logic              saturated;
    } t_cell_update;

    t_cell_update      expected_updates[$];

    // line buffers: fixed flag on top of the temperature
    logic [ENTRY_W-1:0] older_row [MAX_WIDTH];
    logic [ENTRY_W-1:0] upper_row [MAX_WIDTH];
    int unsigned        column;
    t_row_phase         phase;
    logic [GW_W-1:0]    grid_width;
    logic [COEF_W-1:0]  coef;

    function automatic int field_mismatch(input string name, input logic [TEMP_W-1:0] want,
                                          input logic [TEMP_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %h, actual %h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Advance the line buffers by one cell and queue the update it releases.
    task automatic advance_stencil(input logic kind, input logic [IN_TDATA_W-1:0] data);
        logic               pad;
        logic               last;
        logic [ENTRY_W-1:0] entry;
        logic [ENTRY_W-1:0] centre;
        int unsigned        w;
        int unsigned        c;
        longint             t, lft, up, rgt, dn, sum, prod, res, coef_l;
        t_cell_update       upd;

        pad   = (kind == KIND_PADDING);
        entry = pad ? '0 : data[ENTRY_W-1:0];
        w     = grid_width;
        if (w < MIN_GRID_WIDTH) w = MIN_GRID_WIDTH;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        c = column;
        if (c >= MAX_WIDTH) c = MAX_WIDTH - 1;
        last = (c >= w - 1);

        if (phase == PH_FIRST_ROW) begin
            // padding ahead of a grid is dropped without a trace
            if (!pad) begin
                older_row[c] = '0;
                upper_row[c] = entry;
                column = last ? 0 : c + 1;
                if (last) phase = PH_STREAM;
            end
            return;
        end

        centre           = upper_row[c];
        t                = $signed(centre[TEMP_W-1:0]);
        upd.temp         = centre[TEMP_W-1:0];
        upd.fixed        = centre[TEMP_W];
        upd.end_of_grid  = pad && last;
        upd.saturated    = 1'b0;

        // edge columns and fixed cells pass through unchanged
        if (!centre[TEMP_W] && c != 0 && !last) begin
            lft    = $signed(older_row[c-1][TEMP_W-1:0]);
            up     = $signed(older_row[c][TEMP_W-1:0]);
            rgt    = $signed(upper_row[c+1][TEMP_W-1:0]);
            dn     = $signed(entry[TEMP_W-1:0]);
            coef_l = coef;
            sum    = lft + rgt + up + dn - 4 * t;
            prod   = sum * coef_l;
            // round to nearest, ties toward plus infinity
            res    = t + ((prod + ROUND_HALF) >>> COEF_FRAC_BITS);
            if (res > TEMP_MAX) begin
                res = TEMP_MAX;
                upd.saturated = 1'b1;
            end
            if (res < TEMP_MIN) begin
                res = TEMP_MIN;
                upd.saturated = 1'b1;
            end
            upd.temp = res[TEMP_W-1:0];
        end
        expected_updates.push_back(upd);

        older_row[c] = centre;
        upper_row[c] = entry;
        column = last ? 0 : c + 1;
        if (pad && last) phase = PH_FIRST_ROW;
    endtask

    always @(posedge i_clk) begin
        t_cell_update want;

        if (!i_rst_n) begin
            column           = 0;
            phase            = PH_FIRST_ROW;
            grid_width       = GRID_WIDTH_RST;
            coef             = COEF_RST;
            o_mismatch_count = 0;
            expected_updates.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_IDX_GRID_WIDTH) grid_width = i_cfg_data[GW_W-1:0];
                else coef = i_cfg_data;
            end

            if (i_result_valid && i_result_ready) begin
                if (expected_updates.size() == 0) begin
                    $error("result with no cell awaiting it: tdata %h", i_result_data);
                    o_mismatch_count++;
                end else begin
                    want = expected_updates.pop_front();
                    o_mismatch_count += field_mismatch("new_temperature", want.temp,
                                                       i_result_data[TEMP_W-1:0]);
                    o_mismatch_count += field_mismatch("cell_fixed", want.fixed,
                                                       i_result_data[TEMP_W]);
                    o_mismatch_count += field_mismatch("end_of_grid", want.end_of_grid,
                                                       i_result_last);
                    o_mismatch_count += field_mismatch("saturated", want.saturated,
                                                       i_result_saturated);
                end
            end

            if (i_cell_valid && i_cell_ready) advance_stencil(i_cell_kind, i_cell_data);
        end
        o_results_pending = expected_updates.size();
    end

endmodule

### tb/testbench.sv
// testbench: stimulus and verdict for heat_stencil_sweep.
// Drives cells and register writes, stalls the result stream, and relies on
// stencil_result_checker for prediction; depends on hss_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
    import hss_pkg::*;

    localparam int HALF_PERIOD      = 6;
    localparam int QUIET_LIMIT      = 1000;  // cycles without any transaction
    localparam int DRAIN_CYCLES     = 12;    // covers queue plus pipe latency
    localparam int SMALL_GRID_CELLS = 560;
    localparam int SEND_IDLE  [4]   = '{0, 63, 0, 24};
    localparam int RECV_STALL [4]   = '{0, 0, 63, 24};

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tuser  = KIND_GRID;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic                   i_cfg_index   = CFG_IDX_GRID_WIDTH;
    logic [COEF_W-1:0]      i_cfg_data    = '0;

    int          mismatch_count;
    int          results_pending;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          grid_cells     = 0;     // cells sent in the random small grids
    int unsigned active_width   = GRID_WIDTH_RST;
    int          quiet_cycles   = 0;

    always #HALF_PERIOD i_clk = ~i_clk;

    heat_stencil_sweep u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    stencil_result_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cell_valid       (s_axis_tvalid),
        .i_cell_ready       (s_axis_tready),
        .i_cell_data        (s_axis_tdata),
        .i_cell_kind        (s_axis_tuser),
        .i_result_valid     (m_axis_tvalid),
        .i_result_ready     (m_axis_tready),
        .i_result_data      (m_axis_tdata),
        .i_result_saturated (m_axis_tuser),
        .i_result_last      (m_axis_tlast),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_mismatch_count   (mismatch_count),
        .o_results_pending  (results_pending)
    );

    // Stall the result stream at the current rate; zero percent keeps it open.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: end the run when no transaction moves on any channel for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Temperatures lean on the extremes so that clipping in both directions is common.
    function automatic logic [TEMP_W-1:0] random_temp();
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '0;
            3, 4:    return 32'($urandom_range(2097151)) - 32'd1048576;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic random_fixed();
        return $urandom_range(99) < 15;
    endfunction

    // Offer one cell, idling first at the sender rate, and hold it until the transaction.
    task automatic push_cell(input logic kind, input logic [TEMP_W-1:0] temp, input logic fix);
        logic [IN_TDATA_W-1:0] word;

        word              = '0;
        word[TEMP_W-1:0]  = temp;
        word[TEMP_W]      = fix;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Write a register once the block is idle: drop the cell stream, wait for every
    // pending result, then let the pipe drain of cells that release nothing.
    task automatic write_reg(input logic idx, input logic [COEF_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (results_pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // One grid: a first row, further grid rows with stray padding away from the last
    // column, and a flush row of mostly padding that always ends on a padding cell.
    task automatic run_grid(input int unsigned width, input int unsigned rows,
                            input int unsigned noise_pct);
        logic kind;

        for (int unsigned r = 0; r <= rows; r++) begin
            for (int unsigned c = 0; c < width; c++) begin
                if (r == 0) begin
                    // padding while awaiting the first row is dropped by the block
                    if ($urandom_range(99) < 5) push_cell(KIND_PADDING, random_temp(), 1'b1);
                    kind = KIND_GRID;
                end else if (r == rows) begin
                    kind = (c + 1 < width && $urandom_range(99) < 20) ? KIND_GRID : KIND_PADDING;
                end else begin
                    kind = (c + 1 < width && $urandom_range(99) < noise_pct) ? KIND_PADDING
                                                                             : KIND_GRID;
                end
                push_cell(kind, random_temp(), random_fixed());
            end
        end
    endtask

    initial begin
        logic [GW_W-1:0] raw_width;
        int unsigned     rows;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Narrowest grid with the full coefficient; upper data bits are ignored by
        // the width register, and a width of two acts as three.
        write_reg(CFG_IDX_GRID_WIDTH, 16'hF802);
        write_reg(CFG_IDX_COEF, 16'hFFFF);
        push_cell(KIND_PADDING, 32'h1234_5678, 1'b1);   // ahead of any grid row: dropped
        push_cell(KIND_GRID, 32'h7FFF_FFFF, 1'b0);
        push_cell(KIND_GRID, 32'h8000_0000, 1'b0);      // top border reads as zero
        push_cell(KIND_GRID, 32'h7FFF_FFFF, 1'b1);
        push_cell(KIND_GRID, 32'h8000_0000, 1'b0);
        push_cell(KIND_GRID, 32'h7FFF_FFFF, 1'b0);      // centre above clips high
        push_cell(KIND_GRID, 32'h0001_0000, 1'b0);
        push_cell(KIND_GRID, 32'h0000_0000, 1'b1);
        push_cell(KIND_PADDING, 32'hFFFF_FFFF, 1'b1);   // reads as zero; centre clips low
        push_cell(KIND_GRID, 32'h8000_0000, 1'b0);
        push_cell(KIND_GRID, 32'h0000_8000, 1'b0);      // flush row of mixed kinds
        push_cell(KIND_GRID, 32'hFFFF_0000, 1'b1);
        push_cell(KIND_PADDING, 32'hDEAD_BEEF, 1'b1);   // ends the grid

        // Narrow the grid in mid-row: the column past the new edge becomes the last.
        write_reg(CFG_IDX_GRID_WIDTH, 16'd6);
        write_reg(CFG_IDX_COEF, 16'h0000);
        repeat (10) push_cell(KIND_GRID, random_temp(), random_fixed());
        write_reg(CFG_IDX_GRID_WIDTH, 16'd3);
        push_cell(KIND_GRID, random_temp(), 1'b0);
        repeat (3) push_cell(KIND_PADDING, random_temp(), random_fixed());
        active_width = 3;

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = SEND_IDLE[ph];
            recv_stall_pct = RECV_STALL[ph];

            // One full-depth first row: an all-ones width acts as the maximum.
            // Then narrow the grid and flush its first columns with a padding row.
            if (ph == 2) begin
                write_reg(CFG_IDX_GRID_WIDTH, 16'h07FF);
                repeat (1024) push_cell(KIND_GRID, random_temp(), random_fixed());
                write_reg(CFG_IDX_GRID_WIDTH, 16'd3);
                repeat (3) push_cell(KIND_PADDING, random_temp(), random_fixed());
                active_width = 3;
            end

            while (grid_cells < (ph + 1) * SMALL_GRID_CELLS / 4) begin
                if ($urandom_range(99) < 70) begin
                    raw_width = ($urandom_range(9) == 0) ? GW_W'($urandom_range(2))
                                                         : GW_W'($urandom_range(3, 14));
                    write_reg(CFG_IDX_GRID_WIDTH, {5'($urandom), raw_width});
                    active_width = (raw_width < MIN_GRID_WIDTH) ? MIN_GRID_WIDTH : raw_width;
                end
                if ($urandom_range(99) < 50) begin
                    case ($urandom_range(3))
                        0:       write_reg(CFG_IDX_COEF, 16'h0000);
                        1:       write_reg(CFG_IDX_COEF, 16'hFFFF);
                        default: write_reg(CFG_IDX_COEF, COEF_W'($urandom));
                    endcase
                end
                rows = $urandom_range(1, 5);
                run_grid(active_width, rows, 10);
                grid_cells += (rows + 1) * active_width;
            end
        end

        // Drop the stream, collect the last results, then give stray ones a chance.
        s_axis_tvalid <= 1'b0;
        while (results_pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatch_count == 0 && results_pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
